### sv/fdsc_pkg.sv
// ----------------------------------------------------------------------------
// fdsc_pkg
// Shared constants, types and the luma function of the still-frame counter.
// ----------------------------------------------------------------------------
package fdsc_pkg;

  // frame geometry and derived widths
  localparam int unsigned FramePixels = 76800;
  localparam int unsigned AddrW       = (FramePixels > 1) ? $clog2(FramePixels) : 1;
  localparam int unsigned PosW        = $clog2(FramePixels + 1);

  // luma arithmetic: weights sum to 2^14, max sum fits in 22 bits
  localparam int unsigned LumaW       = 22;
  localparam int unsigned LumaShift   = 14;
  localparam logic [13:0] WeightBlue  = 14'd1868;
  localparam logic [13:0] WeightGreen = 14'd9617;
  localparam logic [13:0] WeightRed   = 14'd4899;
  localparam logic [LumaW-1:0] LumaRound = LumaW'(8192);

  // queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // one classified pixel on its way to the back end
  typedef struct packed {
    logic [7:0]       gray;
    logic [AddrW-1:0] addr;
    logic             in_range;
    logic             baseline;
    logic             frame_end;
    logic             chunk_start;
  } pix_t;

  // one per-frame report
  typedef struct packed {
    logic [31:0] still_frame_count;
    logic        baseline_frame;
    logic        motion_seen;
    logic [7:0]  max_difference;
  } result_t;

  // fixed-point gray from bgr, rounded
  function automatic logic [7:0] luma(input logic [7:0] b, input logic [7:0] g,
                                      input logic [7:0] r);
    logic [LumaW-1:0] sum;
    sum = LumaW'(WeightBlue) * LumaW'(b) + LumaW'(WeightGreen) * LumaW'(g)
        + LumaW'(WeightRed) * LumaW'(r) + LumaRound;
    return sum[LumaShift +: 8];
  endfunction

endpackage

### sv/fdsc_ram.sv
// ----------------------------------------------------------------------------
// fdsc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fdsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/fdsc_front.sv
// ----------------------------------------------------------------------------
// fdsc_front
// Accepts pixels, converts to gray and tags position and baseline status.
// ----------------------------------------------------------------------------
module fdsc_front import fdsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
  input  logic        s_axis_tlast,   // frame_end
  input  logic        s_axis_tuser,   // chunk_start
  input  logic        full_i,
  output logic        push_o,
  output pix_t        item_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            base_q, base_d;
  logic            accept;
  logic            in_range;
  logic            baseline;

  assign s_axis_tready = ~full_i;
  assign accept        = s_axis_tvalid & ~full_i;
  assign in_range      = pos_q < PosW'(FramePixels);
  assign baseline      = base_q | s_axis_tuser;

  // classified word for the queue
  always_comb begin
    item_o.gray        = luma(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]);
    item_o.addr        = pos_q[AddrW-1:0];
    item_o.in_range    = in_range;
    item_o.baseline    = baseline;
    item_o.frame_end   = s_axis_tlast;
    item_o.chunk_start = s_axis_tuser;
  end

  assign push_o = accept;

  // position and baseline tracking
  always_comb begin
    pos_d  = pos_q;
    base_d = base_q;
    if (accept) begin
      if (s_axis_tlast) begin
        pos_d  = '0;
        base_d = 1'b0;
      end else begin
        base_d = baseline;
        if (in_range) begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      base_q <= 1'b1;
    end else begin
      pos_q  <= pos_d;
      base_q <= base_d;
    end
  end

endmodule

### sv/fdsc_queue.sv
// ----------------------------------------------------------------------------
// fdsc_queue
// Short fifo of classified pixels between the front and the back end.
// ----------------------------------------------------------------------------
module fdsc_queue import fdsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t item_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output pix_t head_o
);

  pix_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q, rptr_q;
  logic [QueuePtrW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (QueuePtrW+1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = entry_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= item_i;
    end
  end

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QueuePtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (QueuePtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= wptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QueuePtrW'(1);
      end
    end
  end

endmodule

### sv/fdsc_back.sv
// ----------------------------------------------------------------------------
// fdsc_back
// Frame store access, difference tracking, still count and result buffer.
// ----------------------------------------------------------------------------
module fdsc_back import fdsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  pix_t        head_i,
  output logic        pop_o,
  input  logic [7:0]  threshold_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // max_difference [7:0], still_frame_count [39:8]
  output logic [1:0]  m_axis_tuser    // motion_seen [0], baseline_frame [1]
);

  pix_t        b_q;
  logic        b_valid_q;
  logic [7:0]  old_gray;
  logic [7:0]  diff;
  logic [7:0]  new_max;
  logic [7:0]  max_q, max_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] cnt_base;
  logic [31:0] cnt_new;
  logic        motion;
  logic        res_push;
  result_t     res;
  result_t     ofifo_q [2];
  logic        owptr_q, orptr_q;
  logic [1:0]  ocnt_q, ocnt_d;
  logic        b_end;
  logic        out_pop;

  // issue: a frame end only goes when its result has a slot, counting the word leaving now
  assign b_end = b_valid_q & b_q.frame_end;
  assign pop_o = ~empty_i & (~head_i.frame_end |
                 ((3'(ocnt_q) + 3'(b_end)) < (3'd2 + 3'(out_pop))));

  // frame store: old value read and new value written in the same cycle
  fdsc_ram #(
    .Width (8),
    .Depth (FramePixels)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (pop_o & head_i.in_range),
    .waddr_i (head_i.addr),
    .wdata_i (head_i.gray),
    .raddr_i (head_i.addr),
    .rdata_o (old_gray)
  );

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_q <= head_i;
    end
  end

  // difference, maximum and still count
  always_comb begin
    diff = '0;
    if (b_q.in_range && !b_q.baseline) begin
      diff = (b_q.gray > old_gray) ? (b_q.gray - old_gray) : (old_gray - b_q.gray);
    end
    new_max  = (diff > max_q) ? diff : max_q;
    cnt_base = b_q.chunk_start ? 32'd0 : cnt_q;
    motion   = ~b_q.baseline & (new_max > threshold_i);
    cnt_new  = (!motion && cnt_base != '1) ? cnt_base + 32'd1 : cnt_base;

    res.max_difference    = b_q.baseline ? 8'd0 : new_max;
    res.motion_seen       = motion;
    res.baseline_frame    = b_q.baseline;
    res.still_frame_count = cnt_new;
    res_push              = b_end;

    max_d = max_q;
    cnt_d = cnt_q;
    if (b_valid_q) begin
      if (b_q.frame_end) begin
        max_d = '0;
        cnt_d = cnt_new;
      end else begin
        max_d = new_max;
        cnt_d = cnt_base;
      end
    end
  end

  // result buffer, two words
  assign m_axis_tvalid = ocnt_q != 2'd0;
  assign out_pop       = m_axis_tvalid & m_axis_tready;
  assign m_axis_tdata  = {ofifo_q[orptr_q].still_frame_count, ofifo_q[orptr_q].max_difference};
  assign m_axis_tuser  = {ofifo_q[orptr_q].baseline_frame, ofifo_q[orptr_q].motion_seen};

  always_comb begin
    ocnt_d = ocnt_q;
    if (res_push && !out_pop) begin
      ocnt_d = ocnt_q + 2'd1;
    end else if (out_pop && !res_push) begin
      ocnt_d = ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      ofifo_q[owptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      max_q     <= '0;
      cnt_q     <= '0;
      owptr_q   <= 1'b0;
      orptr_q   <= 1'b0;
      ocnt_q    <= '0;
    end else begin
      b_valid_q <= pop_o;
      max_q     <= max_d;
      cnt_q     <= cnt_d;
      ocnt_q    <= ocnt_d;
      if (res_push) begin
        owptr_q <= ~owptr_q;
      end
      if (out_pop) begin
        orptr_q <= ~orptr_q;
      end
    end
  end

endmodule

### sv/frame_difference_still_counter.sv
// ----------------------------------------------------------------------------
// frame_difference_still_counter
// Per-frame motion check by gray frame differencing, with a still count.
// ----------------------------------------------------------------------------
// Takes one bgr pixel per clock in raster order and reports, on each frame's
// last pixel, the largest gray difference to the previous frame, a motion flag
// against still_threshold and a saturating count of still frames in the chunk.
// Sustained rate is one pixel per cycle: the frame store is a single RAM of
// FramePixels bytes that is read and written once per pixel in the same cycle.
// A frame's last pixel passes the pixel queue and the back-end stage register
// before its result enters the result buffer. The input stalls only when the
// four-word pixel queue fills, which happens when a frame end waits for a slot
// in the two-word result buffer. The store needs no clearing after reset: the
// first frame after reset or a chunk start is a baseline that only writes it.
module frame_difference_still_counter import fdsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // still_threshold
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
  input  logic        s_axis_tlast,   // frame_end
  input  logic        s_axis_tuser,   // chunk_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // max_difference [7:0], still_frame_count [39:8]
  output logic [1:0]  m_axis_tuser    // motion_seen [0], baseline_frame [1]
);

  logic [7:0] thr_q;
  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  pix_t       item;
  pix_t       head;

  // threshold register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // front end
  fdsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .item_o        (item)
  );

  // pixel queue
  fdsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  // back end
  fdsc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .threshold_i   (thr_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### tb/frame_difference_still_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_difference_still_counter_test
// Self-checking bench for the frame differencing still-frame counter.
// ----------------------------------------------------------------------------
// Streams bgr pixels with random gaps on both sides and predicts every frame
// report in a scoreboard that keeps its own gray frame store. Covers extreme
// pixels, baseline and chunk restarts in mid frame, single-pixel frames,
// several thresholds and output back-pressure.
module frame_difference_still_counter_test import fdsc_pkg::*; ();

  localparam int unsigned CycleLimit   = 100_000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned LongHold     = 300;

  // scoreboard: gray store, frame maximum and still count, plus due reports
  class frame_report_predictor;
    byte unsigned gray_store [FramePixels];
    int unsigned  position;
    byte unsigned peak;
    bit           baseline;
    int unsigned  still_frames;
    byte unsigned threshold;
    result_t      due_reports [$];
    int unsigned  mismatches;

    function new();
      position     = 0;
      peak         = 0;
      baseline     = 1'b1;
      still_frames = 0;
      threshold    = 0;
      mismatches   = 0;
    endfunction

    function void set_threshold(byte unsigned value);
      threshold = value;
    endfunction

    // one accepted pixel word
    function void take_pixel(logic [7:0] blue, logic [7:0] green, logic [7:0] red,
                             logic frame_end, logic chunk_start);
      int unsigned  weighted;
      byte unsigned gray;
      byte unsigned delta;
      bit           still;
      result_t      report;
      weighted = 32'd1868 * blue + 32'd9617 * green + 32'd4899 * red + 32'd8192;
      gray = 8'(weighted >> 14);
      if (chunk_start) begin
        baseline     = 1'b1;
        still_frames = 0;
      end
      // pixels past the store size are dropped
      if (position < FramePixels) begin
        if (!baseline) begin
          delta = (gray > gray_store[position]) ? gray - gray_store[position]
                                                : gray_store[position] - gray;
          if (delta > peak) peak = delta;
        end
        gray_store[position] = gray;
        position++;
      end
      if (!frame_end) return;
      report = '0;
      report.baseline_frame = baseline;
      if (!baseline) begin
        report.max_difference = peak;
        report.motion_seen    = peak > threshold;
      end
      still = baseline || !report.motion_seen;
      if (still && still_frames != 32'hFFFF_FFFF) still_frames++;
      report.still_frame_count = still_frames;
      due_reports.push_back(report);
      peak     = 0;
      position = 0;
      baseline = 1'b0;
    endfunction

    // one accepted report word
    function void check_report(result_t seen);
      result_t want;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: max %0d motion %0b baseline %0b count %0d",
                   seen.max_difference, seen.motion_seen, seen.baseline_frame,
                   seen.still_frame_count);
        return;
      end
      want = due_reports.pop_front();
      if (seen.max_difference !== want.max_difference ||
          seen.motion_seen !== want.motion_seen ||
          seen.baseline_frame !== want.baseline_frame ||
          seen.still_frame_count !== want.still_frame_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"report mismatch: expected max %0d motion %0b baseline %0b count %0d,",
                    " got max %0d motion %0b baseline %0b count %0d"},
                   want.max_difference, want.motion_seen, want.baseline_frame,
                   want.still_frame_count, seen.max_difference, seen.motion_seen,
                   seen.baseline_frame, seen.still_frame_count);
      end
    endfunction

    function int unsigned pending();
      return due_reports.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;      // still_threshold
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;    // blue [7:0], green [15:8], red [23:16]
  logic        s_axis_tlast;    // frame_end
  logic        s_axis_tuser;    // chunk_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;    // max_difference [7:0], still_frame_count [39:8]
  logic [1:0]  m_axis_tuser;    // motion_seen [0], baseline_frame [1]

  frame_report_predictor predictor;
  bit [23:0]             known_bgr [FramePixels];
  int unsigned           written_extent;
  bit                    next_is_baseline;
  bit                    quiet;
  int unsigned           rx_hold_cycles;
  int unsigned           pixels_sent;
  longint unsigned       cycle_count = 0;

  frame_difference_still_counter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[frame_difference_still_counter] ERROR");
      $finish;
    end
  end

  // watch both streams, pixels first
  always @(posedge clk_i) begin
    result_t seen;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predictor.take_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                           s_axis_tlast, s_axis_tuser);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.max_difference    = m_axis_tdata[7:0];
      seen.still_frame_count = m_axis_tdata[39:8];
      seen.motion_seen       = m_axis_tuser[0];
      seen.baseline_frame    = m_axis_tuser[1];
      predictor.check_report(seen);
    end
  end

  // report sink with random stalls and the occasional long hold
  initial begin : report_sink
    int unsigned gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (rx_hold_cycles != 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (gap != 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // one pixel word, {red, green, blue}, after a random gap
  task automatic push_pixel(input bit [23:0] pixel_word, input bit last, input bit chunk);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pixel_word;
    s_axis_tlast  <= last;
    s_axis_tuser  <= chunk;
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
  endtask

  task automatic rest_sender();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
  endtask

  // wait for every due report, then let the pipeline settle
  task automatic drain_reports(input int unsigned settle);
    while (predictor.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_threshold(input byte unsigned value);
    rest_sender();
    drain_reports(SettleCycles);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    predictor.set_threshold(value);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // move each channel by up to span, clamped
  function automatic bit [23:0] nudge(bit [23:0] base, int unsigned span);
    bit [23:0] moved;
    int        level;
    for (int c = 0; c < 3; c++) begin
      level = int'(base[8*c +: 8]) + int'($urandom_range(0, 2 * span)) - int'(span);
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      moved[8*c +: 8] = level[7:0];
    end
    return moved;
  endfunction

  // span below zero gives fresh random pixels; chunk_start from chunk_from on
  task automatic send_frame(input int unsigned len, input int unsigned chunk_from,
                            input int span);
    bit [23:0] pixel_word;
    for (int unsigned p = 0; p < len; p++) begin
      if (span < 0 || p >= FramePixels) pixel_word = 24'($urandom);
      else pixel_word = nudge(known_bgr[p], span);
      push_pixel(pixel_word, p == len - 1, p >= chunk_from);
      if (p < FramePixels) known_bgr[p] = pixel_word;
    end
    if (len > written_extent) written_extent = (len < FramePixels) ? len : FramePixels;
    next_is_baseline = 1'b0;
  endtask

  // compared frames never reach past what the store holds
  task automatic send_random_frame();
    int unsigned len;
    int unsigned chunk_from;
    int unsigned reach;
    int          span;
    bit          chunk;
    chunk = next_is_baseline || written_extent == 0 || $urandom_range(0, 9) == 0;
    if (chunk) begin
      len = $urandom_range(1, 24);
      reach = len - 1;
      if (!next_is_baseline && written_extent < reach) reach = written_extent;
      chunk_from = ($urandom_range(0, 3) == 0) ? $urandom_range(0, reach) : 0;
    end else begin
      len = $urandom_range(1, (written_extent < 24) ? written_extent : 24);
      chunk_from = len;
    end
    case ($urandom_range(0, 4))
      0: span = -1;
      1: span = 0;
      2: span = 1;
      3: span = 4;
      default: span = 24;
    endcase
    send_frame(len, chunk_from, span);
  endtask

  // stimulus
  initial begin
    byte unsigned threshold;
    int unsigned  target;
    predictor        = new();
    quiet            = 1'b0;
    rx_hold_cycles   = 0;
    written_extent   = 0;
    next_is_baseline = 1'b1;
    pixels_sent      = 0;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    s_axis_tuser  <= 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: first frame after reset is a baseline without chunk_start
    write_threshold(8'd0);
    push_pixel(24'h000000, 1'b0, 1'b0);
    push_pixel(24'hFFFFFF, 1'b0, 1'b0);
    push_pixel(24'h00FF00, 1'b1, 1'b0);
    // full-scale difference, then an identical frame
    repeat (2) begin
      push_pixel(24'hFFFFFF, 1'b0, 1'b0);
      push_pixel(24'h000000, 1'b0, 1'b0);
      push_pixel(24'h00FF00, 1'b1, 1'b0);
    end
    // single-pixel chunk start, then a chunk start in mid frame
    push_pixel(24'h00FF00, 1'b1, 1'b1);
    push_pixel(24'h000000, 1'b0, 1'b0);
    push_pixel(24'h000000, 1'b0, 1'b1);
    push_pixel(24'h00FF00, 1'b1, 1'b1);
    // gray step of one against threshold zero
    push_pixel(24'h000000, 1'b0, 1'b0);
    push_pixel(24'h020000, 1'b1, 1'b0);
    // full-scale difference against the top threshold
    write_threshold(8'd255);
    push_pixel(24'hFFFFFF, 1'b0, 1'b0);
    push_pixel(24'h000000, 1'b1, 1'b0);
    written_extent   = 3;
    next_is_baseline = 1'b0;

    // random phases, each with its own threshold
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: threshold = 8'd0;
        1: threshold = 8'd255;
        2: threshold = 8'($urandom_range(0, 8));
        3: threshold = 8'($urandom_range(0, 40));
        4: threshold = 8'($urandom_range(0, 255));
        default: threshold = 8'd1;
      endcase
      write_threshold(threshold);
      quiet  = (phase == 3);
      target = pixels_sent + 300;
      while (pixels_sent < target) send_random_frame();
      quiet = 1'b0;
      if (phase == 2) begin
        // sender waits out every report, then floods short frames into a held sink
        rest_sender();
        drain_reports(0);
        rx_hold_cycles = LongHold;
        repeat (60) send_frame(1, 1, -1);
        rest_sender();
        drain_reports(0);
      end
    end

    rest_sender();
    drain_reports(SettleCycles);
    if (predictor.mismatches == 0 && predictor.pending() == 0) begin
      $display("[frame_difference_still_counter] OK");
    end else begin
      $display("[frame_difference_still_counter] ERROR");
    end
    $finish;
  end

endmodule
